### hw/rtl/cptc_pkg.sv
// ----------------------------------------------------------------------------
// cptc_pkg: shared types and constants of the prefix-code transcoder
// Holds the character classifier, the fixed prefix-code table and its
// matching function, and the item type carried between the front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cptc_pkg;

   localparam int NUM_WORDS   = 32;
   localparam int MAX_RESULTS = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] NL_CHAR     = 8'd10;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_Z      = 8'h5A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_PERIOD = 8'h2E;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_HYPHEN = 8'h2D;
   localparam logic [7:0] CHAR_APOS   = 8'h27;
   localparam logic [7:0] CHAR_QUEST  = 8'h3F;

   localparam logic [4:0] CODE_SPACE  = 5'd26;
   localparam logic [4:0] CODE_PERIOD = 5'd27;
   localparam logic [4:0] CODE_COMMA  = 5'd28;
   localparam logic [4:0] CODE_HYPHEN = 5'd29;
   localparam logic [4:0] CODE_APOS   = 5'd30;
   localparam logic [4:0] CODE_QUEST  = 5'd31;

   // Codewords are right aligned in CODE_WORD, CODE_LEN bits long.
   localparam logic [7:0] CODE_WORD [NUM_WORDS] = '{
      8'h05, 8'h00, 8'h03, 8'h91, 8'h11, 8'h01, 8'h25, 8'h9A,
      8'h05, 8'h01, 8'h06, 8'h09, 8'h9B, 8'h10, 8'h07, 8'h98,
      8'h06, 8'h04, 8'h99, 8'h9E, 8'h05, 8'h07, 8'h9F, 8'h08,
      8'h06, 8'h07, 8'h9C, 8'h9D, 8'h02, 8'h92, 8'h93, 8'h90
   };
   localparam logic [3:0] CODE_LEN [NUM_WORDS] = '{
      4'd3, 4'd6, 4'd6, 4'd8, 4'd6, 4'd6, 4'd6, 4'd8,
      4'd4, 4'd4, 4'd3, 4'd5, 4'd8, 4'd6, 4'd4, 4'd8,
      4'd4, 4'd5, 4'd8, 4'd8, 4'd5, 4'd3, 4'd8, 4'd4,
      4'd5, 4'd5, 4'd8, 4'd8, 4'd6, 4'd8, 4'd8, 4'd8
   };
   localparam logic [7:0] CODE_SYM [NUM_WORDS] = '{
      8'h20, 8'h27, 8'h2C, 8'h2D, 8'h2E, 8'h3F, 8'h41, 8'h42,
      8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
      8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52,
      8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A
   };

   typedef struct packed {
      logic       is_nl;
      logic [4:0] code;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [4:0] code;
   } class_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] len;
      logic [7:0] sym;
   } match_type;

   // Maps a character to its 5-bit code; valid is low for unmapped ones.
   function automatic class_type char_class(input logic [7:0] c);
      class_type r;
      r = '0;
      if (c >= CHAR_A && c <= CHAR_Z) begin
         r.valid = 1'b1;
         r.code  = 5'(c - CHAR_A);
      end else begin
         unique case (c)
            CHAR_SPACE:  r = '{valid: 1'b1, code: CODE_SPACE};
            CHAR_PERIOD: r = '{valid: 1'b1, code: CODE_PERIOD};
            CHAR_COMMA:  r = '{valid: 1'b1, code: CODE_COMMA};
            CHAR_HYPHEN: r = '{valid: 1'b1, code: CODE_HYPHEN};
            CHAR_APOS:   r = '{valid: 1'b1, code: CODE_APOS};
            CHAR_QUEST:  r = '{valid: 1'b1, code: CODE_QUEST};
            default:     r = '0;
         endcase
      end
      return r;
   endfunction

   // Matches the oldest pending bits. The window holds them left aligned
   // (oldest in bit 7); avail is how many of its bits are real (0..8).
   function automatic match_type match_word(input logic [7:0] window,
                                            input logic [3:0] avail);
      match_type r;
      logic [7:0] head;
      r = '0;
      head = '0;
      // Scanned from the end so that the lowest table index wins.
      for (int i = NUM_WORDS - 1; i >= 0; i--) begin
         head = window >> (4'd8 - CODE_LEN[i]);
         if (CODE_LEN[i] <= avail && head == CODE_WORD[i]) begin
            r.hit = 1'b1;
            r.len = CODE_LEN[i];
            r.sym = CODE_SYM[i];
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/cptc_front.sv
// ----------------------------------------------------------------------------
// cptc_front: input classifier
// Accepts characters, drops unmapped ones and pushes newline or code items
// into the work queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cptc_front
   import cptc_pkg::*;
(
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_char
   output logic            q_wr_valid,
   input  wire logic       q_wr_ready,
   output item_type        q_wr_item
);

   class_type cls;

   assign cls        = char_class(req_tdata);
   // Unmapped characters are taken and dropped only while the queue has room,
   // so transaction order is never disturbed.
   assign req_tready = q_wr_ready;
   assign q_wr_valid = req_tvalid && (cls.valid || req_tdata == NL_CHAR);
   assign q_wr_item  = '{is_nl: (req_tdata == NL_CHAR), code: cls.code};

endmodule

`default_nettype wire

### hw/rtl/cptc_queue.sv
// ----------------------------------------------------------------------------
// cptc_queue: work queue between front and back
// A small FIFO of classified items so each side can stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cptc_queue
   import cptc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     wr_valid,
   output logic          wr_ready,
   input  wire item_type wr_item,
   output logic          rd_valid,
   input  wire logic     rd_ready,
   output item_type      rd_item
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type        slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push, pop;

   assign wr_ready = (count_ff != CW'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_item  = slot_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/cptc_back.sv
// ----------------------------------------------------------------------------
// cptc_back: bit buffer and prefix-code decoder
// Appends codes to the pending bit buffer and emits one decoded character
// per cycle into the output register while the receiver does not stall it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cptc_back
   import cptc_pkg::*;
#(
   parameter int BUFFER_BITS = 12
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_rd_valid,
   output logic            q_rd_ready,
   input  wire item_type   q_rd_item,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_char
   output logic            rsp_tlast
);

   localparam int CW = $clog2(BUFFER_BITS + 1);
   localparam int NW = $clog2(MAX_RESULTS);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                   state_ff, state_in;
   logic [BUFFER_BITS-1:0] bits_ff, bits_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [NW-1:0]          n_ff, n_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             rsp_data_ff, rsp_data_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   out_free;
   logic                   fits;
   logic [BUFFER_BITS+7:0] wide_cur, wide_next;
   logic [3:0]             avail_cur, avail_next;
   match_type              cur, nxt;
   logic [CW-1:0]          rem_count;
   logic [BUFFER_BITS-1:0] rem_bits;
   logic                   emit_last;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign fits     = ({1'b0, count_ff} + (CW+1)'(5)) <= (CW+1)'(BUFFER_BITS);

   // Oldest pending bits, left aligned in an 8-bit window.
   assign wide_cur  = {bits_ff, 8'h00} >> count_ff;
   assign avail_cur = (count_ff >= CW'(8)) ? 4'd8 : count_ff[3:0];
   assign cur       = match_word(wide_cur[7:0], avail_cur);

   assign rem_count = count_ff - CW'(cur.len);
   assign rem_bits  = bits_ff & ~({BUFFER_BITS{1'b1}} << rem_count);

   // Look one codeword ahead to decide whether this result is the last.
   assign wide_next  = {rem_bits, 8'h00} >> rem_count;
   assign avail_next = (rem_count >= CW'(8)) ? 4'd8 : rem_count[3:0];
   assign nxt        = match_word(wide_next[7:0], avail_next);
   assign emit_last  = !nxt.hit || (n_ff == NW'(MAX_RESULTS - 1));

   always_comb begin
      state_in     = state_ff;
      bits_in      = bits_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      q_rd_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_rd_valid) begin
               if (q_rd_item.is_nl) begin
                  if (out_free) begin
                     q_rd_ready   = 1'b1;
                     bits_in      = '0;
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = NL_CHAR;
                     rsp_last_in  = 1'b1;
                  end
               end else begin
                  q_rd_ready = 1'b1;
                  if (fits) begin
                     bits_in  = BUFFER_BITS'({bits_ff, q_rd_item.code});
                     count_in = count_ff + CW'(5);
                     n_in     = '0;
                     state_in = ST_RUN;
                  end
               end
            end
         end
         ST_RUN: begin
            if (!cur.hit) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = cur.sym;
               rsp_last_in  = emit_last;
               bits_in      = rem_bits;
               count_in     = rem_count;
               n_in         = n_ff + 1'b1;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bits_ff      <= '0;
         count_ff     <= '0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bits_ff      <= bits_in;
         count_ff     <= count_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

### hw/rtl/char_to_prefix_code_transcoder.sv
// ----------------------------------------------------------------------------
// char_to_prefix_code_transcoder: character to prefix-code transcoder
// Turns a stream of characters into 5-bit codes and decodes the resulting
// bit stream against a fixed 32-word prefix code.
// ----------------------------------------------------------------------------
// Usage:
// Each req transaction carries one ASCII character in req_tdata. Letters A-Z
// and the characters space . , - ' ? are mapped to 5-bit codes and appended
// to a pending bit buffer; every complete codeword at the head of the buffer
// yields one rsp transaction (up to four per request) with the decoded
// character in rsp_tdata. The final result caused by one request has
// rsp_tlast set. A newline drops the pending bits and echoes one newline
// with rsp_tlast set; other characters are accepted and give no result.
// A character's result passes through the work queue, the load into the
// pending buffer and the output register; a newline echo goes from the work
// queue straight into the output register. The decoder emits one result per
// cycle while the receiver takes them: a character is first loaded, then
// each result follows, and one that completes no codeword is loaded and
// then finds no match. The decoder takes the next queued item only once it
// is through with the pending buffer.
// The front classifier and the decoder are parted by a two-entry work queue,
// and the result sits in an output register, so a stalled receiver only holds
// the decoder; requests keep being taken until the queue fills.
// Reset clears the pending buffer, the queue and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module char_to_prefix_code_transcoder
   import cptc_pkg::*;
#(
   parameter int BUFFER_BITS = 12
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_char
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_char
   output logic            rsp_tlast
);

   logic     q_wr_valid, q_wr_ready;
   item_type q_wr_item;
   logic     q_rd_valid, q_rd_ready;
   item_type q_rd_item;

   // Front: classifies characters and drops the unmapped ones.
   cptc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_wr_valid (q_wr_valid),
      .q_wr_ready (q_wr_ready),
      .q_wr_item  (q_wr_item)
   );

   // Work queue decoupling the classifier from the decoder.
   cptc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (q_wr_valid),
      .wr_ready (q_wr_ready),
      .wr_item  (q_wr_item),
      .rd_valid (q_rd_valid),
      .rd_ready (q_rd_ready),
      .rd_item  (q_rd_item)
   );

   // Back: bit buffer, codeword matcher and output register.
   cptc_back #(
      .BUFFER_BITS (BUFFER_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_rd_valid (q_rd_valid),
      .q_rd_ready (q_rd_ready),
      .q_rd_item  (q_rd_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

### dv/char_to_prefix_code_checker.sv
// ----------------------------------------------------------------------------
// char_to_prefix_code_checker: result predictor and comparator
// Watches both streams of the transcoder, decodes every accepted character
// with its own copy of the pending bit buffer and compares each result
// transaction in order against the predicted characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module char_to_prefix_code_checker
   import cptc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_char
   input  wire logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire logic [7:0] rsp_tdata,   // [7:0] out_char
   input  wire logic       rsp_tlast,
   output int              failures,
   output int              outstanding,
   output int              checked
);

   localparam int HELD_BITS = 12;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
   } decoded_char_type;

   decoded_char_type decoded_q [$];
   logic [HELD_BITS-1:0] held_bits = '0;
   logic [3:0]           held_count = '0;

   // Appends the 5-bit code of one character and peels complete codewords
   // off the oldest end of the held bits.
   task automatic decode_char(input logic [7:0] c);
      logic [4:0] code;
      logic       mapped;
      logic [7:0] head;
      logic [7:0] syms [MAX_RESULTS];
      int         n;
      int         hit;
      mapped = 1'b1;
      code = '0;
      n = 0;
      if (c == NL_CHAR) begin
         held_bits = '0;
         held_count = '0;
         decoded_q.push_back('{out_char: NL_CHAR, last: 1'b1});
         return;
      end
      if (c >= CHAR_A && c <= CHAR_Z) begin
         code = 5'(c - CHAR_A);
      end else begin
         case (c)
            CHAR_SPACE:  code = CODE_SPACE;
            CHAR_PERIOD: code = CODE_PERIOD;
            CHAR_COMMA:  code = CODE_COMMA;
            CHAR_HYPHEN: code = CODE_HYPHEN;
            CHAR_APOS:   code = CODE_APOS;
            CHAR_QUEST:  code = CODE_QUEST;
            default:     mapped = 1'b0;
         endcase
      end
      if (!mapped || held_count + 5 > HELD_BITS) return;
      held_bits = {held_bits[HELD_BITS-6:0], code};
      held_count = held_count + 4'd5;
      while (n < MAX_RESULTS) begin
         hit = -1;
         for (int i = 0; i < NUM_WORDS && hit < 0; i++) begin
            if (CODE_LEN[i] <= held_count) begin
               head = 8'(held_bits >> (held_count - CODE_LEN[i]))
                      & (8'hFF >> (4'd8 - CODE_LEN[i]));
               if (head == CODE_WORD[i]) hit = i;
            end
         end
         if (hit < 0) break;
         held_count = held_count - CODE_LEN[hit];
         held_bits = held_bits & ((HELD_BITS'(1) << held_count) - 1'b1);
         syms[n] = CODE_SYM[hit];
         n++;
      end
      for (int k = 0; k < n; k++)
         decoded_q.push_back('{out_char: syms[k], last: (k == n - 1)});
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_bits = '0;
         held_count = '0;
         decoded_q.delete();
      end else begin
         if (req_tvalid && req_tready) decode_char(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (decoded_q.size() == 0) begin
               $error("unexpected result transaction: out_char %h, last %b",
                      rsp_tdata, rsp_tlast);
               failures++;
            end else begin
               decoded_char_type want;
               want = decoded_q.pop_front();
               checked++;
               if (rsp_tdata !== want.out_char) begin
                  $error("out_char mismatch: expected %h, actual %h",
                         want.out_char, rsp_tdata);
                  failures++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last mismatch: expected %b, actual %b", want.last, rsp_tlast);
                  failures++;
               end
            end
         end
      end
      outstanding <= decoded_q.size();
   end

endmodule

`default_nettype wire

### dv/char_to_prefix_code_transcoder_test.sv
// ----------------------------------------------------------------------------
// char_to_prefix_code_transcoder_test: top level of the transcoder testbench
// Drives characters into the transcoder, paces the result stream and gives
// the verdict; prediction and comparison live in the checker beside it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module char_to_prefix_code_transcoder_test
   import cptc_pkg::*;
();

   // Number of mapped characters and newlines in the random part.
   localparam int RANDOM_ITEMS = 300;
   // Cycles the receiver refuses results during the back-pressure phase.
   localparam int RSP_HOLD_CYCLES = 80;
   // Cycles allowed after the last expectation is met, and the drain limit.
   localparam int TAIL_CYCLES = 20;
   localparam int DRAIN_LIMIT = 5000;
   // Generous wall for the whole run, in nanoseconds.
   localparam int RUN_LIMIT_NS = 4_000_000;

   // A short directed opening: an empty newline, every special character,
   // the letter extremes, a character left pending across a run of ignored
   // bytes, a newline dropping pending bits, and repeated question marks
   // that release several codewords in one go.
   localparam logic [7:0] DIRECTED [24] = '{
      NL_CHAR,
      CHAR_SPACE, CHAR_PERIOD, CHAR_COMMA, CHAR_HYPHEN, CHAR_APOS, CHAR_QUEST,
      CHAR_A, CHAR_Z, 8'h4D,                           // M
      NL_CHAR, 8'h54,                                  // T stays pending
      8'h00, 8'hFF, 8'h61, 8'h30, 8'h7F, 8'h80, 8'h09, // all ignored
      8'h4A,                                           // J completes a codeword
      NL_CHAR,                                         // drops the leftover bits
      CHAR_QUEST, CHAR_QUEST, CHAR_QUEST
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;    // [7:0] in_char
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // [7:0] out_char
   logic       rsp_tlast;

   int failures;
   int outstanding;
   int checked;

   // Pacing controls shared between the sender and the receiver.
   bit quiet_stretch = 1'b0;  // neither side idles while set
   bit hold_off_req = 1'b0;   // asks the receiver for one long hold-off
   bit sender_eager = 1'b0;   // the sender alone never idles while set

   int chars_sent = 0;
   int noise_sent = 0;
   int newlines_sent = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   char_to_prefix_code_transcoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   char_to_prefix_code_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .failures    (failures),
      .outstanding (outstanding),
      .checked     (checked)
   );

   // Offers one character and returns in the time step of the edge that
   // accepted it. Valid is only lowered inside idle cycles, so back-to-back
   // transactions keep it high without a second assignment in one step.
   task automatic send_char(input logic [7:0] c);
      if (!quiet_stretch && !sender_eager) begin
         while ($urandom_range(0, 99) < 25) begin
            req_tvalid <= 1'b0;
            req_tdata <= 8'($urandom_range(0, 255));
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      do @(posedge clock); while (!req_tready);
      if (c == NL_CHAR) newlines_sent++;
      chars_sent++;
   endtask

   // Stops offering until the checker holds no expectation. The first edge
   // lets the checker take in the transaction accepted in this step.
   task automatic wait_drained();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // A mapped character with random content; spaces come more often, so the
   // stream looks like words on a line.
   function automatic logic [7:0] random_symbol();
      logic [4:0] code;
      if ($urandom_range(0, 99) < 15) return CHAR_SPACE;
      code = 5'($urandom_range(0, 31));
      case (code)
         CODE_SPACE:  return CHAR_SPACE;
         CODE_PERIOD: return CHAR_PERIOD;
         CODE_COMMA:  return CHAR_COMMA;
         CODE_HYPHEN: return CHAR_HYPHEN;
         CODE_APOS:   return CHAR_APOS;
         CODE_QUEST:  return CHAR_QUEST;
         default:     return CHAR_A + 8'(code);
      endcase
   endfunction

   // Receiver: ready drops in about a quarter of the cycles, except in the
   // quiet stretch and during the one long hold-off, which it counts itself.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= quiet_stretch || ($urandom_range(0, 99) >= 25);
         end
      end
   end

   // Hard wall on the run time.
   initial begin
      #(RUN_LIMIT_NS);
      $display("Run stopped by timeout with %0d results still expected.", outstanding);
      $display("TB_ERROR");
      $finish;
   end

   // Stimulus and verdict.
   initial begin
      int words_sent;
      int lines_sent;
      int line_len;
      int waited;
      words_sent = 0;
      lines_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) send_char(DIRECTED[i]);
      // The sender rests until every result of the opening has come back.
      wait_drained();

      // Back-pressure: the receiver holds off while the sender keeps offering
      // without gaps, so the work queue fills and the input side stalls.
      hold_off_req = 1'b1;
      sender_eager = 1'b1;
      for (int k = 0; k < 16; k++) send_char(random_symbol());
      sender_eager = 1'b0;
      wait_drained();

      // Random lines of mapped characters, with stray bytes mixed in and the
      // odd line that runs on without its newline. Stray bytes do not count.
      while (words_sent < RANDOM_ITEMS) begin
         line_len = $urandom_range(1, 20);
         for (int k = 0; k < line_len; k++) begin
            if ($urandom_range(0, 99) < 9) begin
               send_char(8'($urandom_range(0, 255)));
               noise_sent++;
            end else begin
               send_char(random_symbol());
               words_sent++;
            end
         end
         if ($urandom_range(0, 9) != 0) begin
            send_char(NL_CHAR);
            words_sent++;
         end
         lines_sent++;
         quiet_stretch = (lines_sent >= 6 && lines_sent < 12);
         if (lines_sent % 10 == 0) wait_drained();
      end
      quiet_stretch = 1'b0;

      // Let every expected result arrive, then a few more cycles in which a
      // stray result transaction would still be caught.
      req_tvalid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (outstanding != 0) $error("%0d expected results never arrived", outstanding);

      $display("Sent %0d characters (%0d random bytes, %0d newlines) over %0d lines;",
               chars_sent, noise_sent, newlines_sent, lines_sent);
      $display("compared %0d decoded results, with one long receiver hold-off.", checked);
      if (failures == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/cptc_pkg.sv
hw/rtl/cptc_front.sv
hw/rtl/cptc_queue.sv
hw/rtl/cptc_back.sv
hw/rtl/char_to_prefix_code_transcoder.sv
dv/char_to_prefix_code_checker.sv
dv/char_to_prefix_code_transcoder_test.sv
